FILE: design/i2r_pkg.sv
package i2r_pkg;

  localparam int VALUE_W   = 12;
  localparam int SYM_W     = 7;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 8;
  localparam int DIGIT_W   = 4;
  localparam int TH_W      = 3;
  localparam int LEN_W     = 3;
  localparam int POS_W     = 2;
  localparam int NPLACE    = 4;

  // ASCII codes of the Roman symbols
  localparam logic [SYM_W-1:0] CH_I = 7'h49;
  localparam logic [SYM_W-1:0] CH_V = 7'h56;
  localparam logic [SYM_W-1:0] CH_X = 7'h58;
  localparam logic [SYM_W-1:0] CH_L = 7'h4C;
  localparam logic [SYM_W-1:0] CH_C = 7'h43;
  localparam logic [SYM_W-1:0] CH_D = 7'h44;
  localparam logic [SYM_W-1:0] CH_M = 7'h4D;

  // Decimal place; the code is also the bit index in the nonzero-digit mask.
  typedef enum logic [1:0] {
    PL_UNITS     = 2'd0,
    PL_TENS      = 2'd1,
    PL_HUNDREDS  = 2'd2,
    PL_THOUSANDS = 2'd3
  } place_t;

  typedef enum logic [1:0] {
    ROLE_ONE  = 2'd0,
    ROLE_FIVE = 2'd1,
    ROLE_TEN  = 2'd2
  } role_t;

  // Number of characters one digit expands to. Thousands are plain repeats of M.
  function automatic logic [LEN_W-1:0] digit_len(place_t pl, logic [DIGIT_W-1:0] d);
    logic [LEN_W-1:0] n;
    if (pl == PL_THOUSANDS) begin
      n = d[LEN_W-1:0];
    end else begin
      case (d)
        4'd0:    n = 3'd0;
        4'd1:    n = 3'd1;
        4'd2:    n = 3'd2;
        4'd3:    n = 3'd3;
        4'd4:    n = 3'd2;
        4'd5:    n = 3'd1;
        4'd6:    n = 3'd2;
        4'd7:    n = 3'd3;
        4'd8:    n = 3'd4;
        4'd9:    n = 3'd2;
        default: n = 3'd0;
      endcase
    end
    return n;
  endfunction

  // Character at position pos within the expansion of digit d at place pl.
  function automatic logic [SYM_W-1:0] digit_sym(place_t pl, logic [DIGIT_W-1:0] d,
                                                 logic [POS_W-1:0] pos);
    role_t            role;
    logic [SYM_W-1:0] ch;
    role = ROLE_ONE;
    if (pl != PL_THOUSANDS) begin
      if (d inside {[4'd5:4'd8]} && pos == 2'd0) begin
        role = ROLE_FIVE;
      end else if (d == 4'd4 && pos == 2'd1) begin
        role = ROLE_FIVE;
      end else if (d == 4'd9 && pos == 2'd1) begin
        role = ROLE_TEN;
      end
    end
    case (pl)
      PL_UNITS:     ch = (role == ROLE_ONE) ? CH_I : (role == ROLE_FIVE) ? CH_V : CH_X;
      PL_TENS:      ch = (role == ROLE_ONE) ? CH_X : (role == ROLE_FIVE) ? CH_L : CH_C;
      PL_HUNDREDS:  ch = (role == ROLE_ONE) ? CH_C : (role == ROLE_FIVE) ? CH_D : CH_M;
      PL_THOUSANDS: ch = CH_M;
      default:      ch = CH_M;
    endcase
    return ch;
  endfunction

  // Most significant place with a nonzero digit.
  function automatic place_t top_place(logic [NPLACE-1:0] mask);
    place_t pl;
    if (mask[3]) begin
      pl = PL_THOUSANDS;
    end else if (mask[2]) begin
      pl = PL_HUNDREDS;
    end else if (mask[1]) begin
      pl = PL_TENS;
    end else begin
      pl = PL_UNITS;
    end
    return pl;
  endfunction

endpackage

FILE: design/integer_to_roman_numeral_top.sv
// An accepted word moves on to the numeral register once the output side is free
//   (two-register path: input word, then numeral), which then shows its characters.
// Throughput: one character per cycle while m_tready is high and the next word is
//   waiting; a numeral has 1 to 15 characters. A zero word leaves no output.
// Reset: rst is synchronous, active high; it empties both registers.
module integer_to_roman_numeral_top
  import i2r_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [11:0] value, [15:12] zero
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [6:0] symbol (ASCII), [7] zero
  output logic                 m_tlast
);

  // Input register
  logic               in_valid;
  logic [VALUE_W-1:0] in_value;

  // Numeral register: decimal digits plus a read pointer (place, char in digit)
  logic                out_valid;
  logic [TH_W-1:0]     dig_th;
  logic [DIGIT_W-1:0]  dig_h;
  logic [DIGIT_W-1:0]  dig_t;
  logic [DIGIT_W-1:0]  dig_u;
  logic [NPLACE-1:0]   nz;
  place_t              place;
  logic [POS_W-1:0]    pos;

  // Digit split by reciprocal multiplies; exact for every 12-bit value.
  //   v/1000 = (v*4195)>>22, v/100 = (v*5243)>>19, v/10 = (v*3277)>>15
  logic [24:0]        prod_k;
  logic [24:0]        prod_h;
  logic [23:0]        prod_t;
  logic [TH_W-1:0]    split_th;
  logic [5:0]         div100;
  logic [8:0]         div10;
  logic [DIGIT_W-1:0] split_h;
  logic [DIGIT_W-1:0] split_t;
  logic [DIGIT_W-1:0] split_u;
  logic [NPLACE-1:0]  split_nz;
  logic               in_zero;

  assign prod_k   = 25'(in_value) * 25'd4195;
  assign prod_h   = 25'(in_value) * 25'd5243;
  assign prod_t   = 24'(in_value) * 24'd3277;
  assign split_th = prod_k[24:22];
  assign div100   = prod_h[24:19];
  assign div10    = prod_t[23:15];
  assign split_h  = 4'(div100 - 6'({3'b000, split_th} * 6'd10));
  assign split_t  = 4'(div10 - 9'({3'b000, div100} * 9'd10));
  assign split_u  = 4'(in_value - 12'({3'b000, div10} * 12'd10));
  assign split_nz = {split_th != '0, split_h != '0, split_t != '0, split_u != '0};
  assign in_zero  = (in_value == '0);

  // Current character
  logic [DIGIT_W-1:0] cur_digit;
  logic [LEN_W-1:0]   cur_len;
  logic [SYM_W-1:0]   cur_sym;
  logic [NPLACE-1:0]  below;
  logic [NPLACE-1:0]  rest;
  logic               end_of_digit;
  logic               is_last;

  always_comb begin
    case (place)
      PL_THOUSANDS: cur_digit = {1'b0, dig_th};
      PL_HUNDREDS:  cur_digit = dig_h;
      PL_TENS:      cur_digit = dig_t;
      PL_UNITS:     cur_digit = dig_u;
      default:      cur_digit = dig_u;
    endcase
    case (place)
      PL_THOUSANDS: below = 4'b0111;
      PL_HUNDREDS:  below = 4'b0011;
      PL_TENS:      below = 4'b0001;
      PL_UNITS:     below = 4'b0000;
      default:      below = 4'b0000;
    endcase
  end

  assign cur_len      = digit_len(place, cur_digit);
  assign cur_sym      = digit_sym(place, cur_digit, pos);
  assign rest         = nz & below;    // nonzero places still to come
  assign end_of_digit = (LEN_W'(pos) + 3'd1 == cur_len);
  assign is_last      = end_of_digit && (rest == '0);

  // Handshake
  logic out_fire;
  logic out_free;
  logic load;
  logic in_drain;
  logic s_fire;

  assign out_fire = out_valid && m_tready;
  assign out_free = !out_valid || (out_fire && is_last);
  assign load     = in_valid && !in_zero && out_free;
  assign in_drain = in_valid && (in_zero || out_free);   // zero words just drop
  assign s_tready = !in_valid || in_drain;
  assign s_fire   = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, cur_sym};
  assign m_tlast  = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_valid  <= s_fire || (in_valid && !in_drain);
      out_valid <= load || (out_valid && !(out_fire && is_last));
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_value <= s_tdata[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dig_th <= split_th;
      dig_h  <= split_h;
      dig_t  <= split_t;
      dig_u  <= split_u;
      nz     <= split_nz;
      place  <= top_place(split_nz);
      pos    <= '0;
    end else if (out_fire && end_of_digit) begin
      place  <= top_place(rest);
      pos    <= '0;
    end else if (out_fire) begin
      pos    <= pos + 2'd1;
    end
  end

endmodule

FILE: design/i2r_checker.sv
module i2r_checker
  import i2r_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tlast
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output word changed");

  a_symbol_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7] == 1'b0 &&
      (m_tdata[6:0] == CH_I || m_tdata[6:0] == CH_V || m_tdata[6:0] == CH_X ||
       m_tdata[6:0] == CH_L || m_tdata[6:0] == CH_C || m_tdata[6:0] == CH_D ||
       m_tdata[6:0] == CH_M))
    else $error("output word is not a Roman symbol");

  a_run_unbroken: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("numeral interrupted before its last word");

  a_v_then_i: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast && m_tdata[6:0] == CH_V |=> m_tdata[6:0] == CH_I)
    else $error("V followed by something other than I");

endmodule

bind integer_to_roman_numeral_top i2r_checker u_i2r_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
